@@ hdl/rosa_pkg.sv @@
`default_nettype none
package rosa_pkg;

  // Table geometry.
  localparam int SLOTS      = 32;
  localparam int OWNER_BITS = 16;

  // Fixed field widths of the ports.
  localparam int OWNER_IN_W = 16;
  localparam int RND_W      = 32;
  localparam int CFG_W      = 6;
  localparam int SLOT_W     = 5;
  localparam int REL_W      = 6;

  // Derived widths.
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int STEP_W = $clog2(RND_W);

  localparam logic ACT_ACQUIRE = 1'b0;
  localparam logic ACT_RELEASE = 1'b1;

  typedef logic [OWNER_BITS-1:0] owner_t;

  // One write into the owner table.
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    owner_t           data;
  } rosa_wr_t;

endpackage
`default_nettype wire

@@ hdl/rosa_owner_ram.sv @@
`default_nettype none
module rosa_owner_ram (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      rd_en,
  input  wire logic [rosa_pkg::IDX_W-1:0] rd_addr,
  output logic [rosa_pkg::OWNER_BITS-1:0] rd_data,
  input  wire rosa_pkg::rosa_wr_t        wr
);
  import rosa_pkg::*;

  owner_t             mem [SLOTS];
  logic [SLOTS-1:0]   valid_r;
  owner_t             rd_data_r;

  // An entry that was never written since reset reads as a free slot.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr.en) begin
      valid_r[wr.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_data_r <= valid_r[rd_addr] ? mem[rd_addr] : '0;
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

@@ hdl/rosa_mod_unit.sv @@
`default_nettype none
module rosa_mod_unit (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [rosa_pkg::RND_W-1:0] dividend,
  input  wire logic [rosa_pkg::CNT_W-1:0] divisor,
  output logic                            done,
  output logic [rosa_pkg::CNT_W-1:0]      remainder
);
  import rosa_pkg::*;

  logic [RND_W-1:0]  dvd_r;
  logic [CNT_W-1:0]  dsr_r;
  logic [CNT_W-1:0]  rem_r;
  logic [STEP_W-1:0] step_r;
  logic              busy_r;
  logic              done_r;
  logic [CNT_W:0]    trial;
  logic [CNT_W:0]    diff;

  // Restoring division, one dividend bit per cycle, remainder only.
  assign trial = {rem_r, dvd_r[RND_W-1]};
  assign diff  = trial - {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == STEP_W'(RND_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dsr_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[RND_W-2:0], 1'b0};
      if (trial >= {1'b0, dsr_r}) begin
        rem_r <= diff[CNT_W-1:0];
      end else begin
        rem_r <= trial[CNT_W-1:0];
      end
    end
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule
`default_nettype wire

@@ hdl/random_owner_slot_allocator_unit.sv @@
`default_nettype none
// One word at a time: a request is taken only in the idle state, and the next one only after
// its result has moved into the output register. With n active slots (at most SLOTS), a
// release or an acquire without candidates scans the n entries once; a grant scans them
// twice, with a remainder division between the scans, all through the single RAM read port.
// Reset (rst_n, synchronous, active low) frees every slot at once through per-entry
// valid bits and clears the active slot count, so no clearing pass is needed.
module random_owner_slot_allocator_unit (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [rosa_pkg::CFG_W-1:0]       cfg_wdata,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic                             in_action,
  input  wire logic [rosa_pkg::OWNER_IN_W-1:0]  in_owner_id,
  input  wire logic [rosa_pkg::RND_W-1:0]       in_random_value,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic                                  out_found,
  output logic [rosa_pkg::SLOT_W-1:0]           out_slot_index,
  output logic [rosa_pkg::REL_W-1:0]            out_released_count
);
  import rosa_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CNT,
    S_MOD,
    S_PICK,
    S_DONE
  } state_t;

  state_t            state_r;
  logic [CFG_W-1:0]  slots_in_use_r;

  // Latched request.
  logic              action_r;
  owner_t            owner_r;
  logic [RND_W-1:0]  rnd_r;
  logic [CNT_W-1:0]  n_r;

  // Scan pipeline: one read issued per cycle, its data arrives in the next cycle.
  logic [CNT_W-1:0]  rd_idx_r;
  logic              rd_vld_r;
  logic [IDX_W-1:0]  data_idx_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [CNT_W-1:0]  seen_r;
  logic              hit_r;
  logic [IDX_W-1:0]  hit_idx_r;

  logic              out_valid_r;
  logic              out_found_r;
  logic [SLOT_W-1:0] out_slot_index_r;
  logic [REL_W-1:0]  out_released_count_r;

  logic              rd_en;
  owner_t            rd_data;
  rosa_wr_t          wr;
  logic              scanning;
  logic              scan_end;
  logic              is_cand;
  logic              is_mine;
  logic              is_pick;
  logic              mod_start;
  logic              mod_done;
  logic [CNT_W-1:0]  pick;
  logic [CNT_W-1:0]  n_nxt;

  // The register may exceed the table size; the active count saturates at SLOTS.
  assign n_nxt = (CMP_W'(slots_in_use_r) > CMP_W'(SLOTS)) ? CNT_W'(SLOTS)
                                                         : CNT_W'(slots_in_use_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slots_in_use_r <= '0;
    end else if (cfg_we) begin
      slots_in_use_r <= cfg_wdata;
    end
  end

  assign scanning = (state_r == S_CNT) || (state_r == S_PICK);
  assign rd_en    = scanning && (rd_idx_r < n_r);
  assign scan_end = scanning && !rd_en && !rd_vld_r;

  // A candidate is a free slot or one already held by the requester. A release
  // by owner zero matches nothing, so free slots are never counted as cleared.
  assign is_cand = (rd_data == '0) || (rd_data == owner_r);
  assign is_mine = (owner_r != '0) && (rd_data == owner_r);
  assign is_pick = rd_vld_r && (state_r == S_PICK) && is_cand && (seen_r == pick);

  // Writes always land behind the read pointer, so a read never meets a pending
  // write to the same entry.
  always_comb begin
    wr.en   = rd_vld_r && (state_r == S_CNT) && (action_r == ACT_RELEASE) && is_mine;
    wr.en   = wr.en || is_pick;
    wr.addr = data_idx_r;
    wr.data = (action_r == ACT_RELEASE) ? '0 : owner_r;
  end

  assign mod_start = scan_end && (state_r == S_CNT) && (action_r == ACT_ACQUIRE) &&
                     (cnt_r != '0);

  rosa_owner_ram u_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (rd_idx_r[IDX_W-1:0]),
    .rd_data (rd_data),
    .wr      (wr)
  );

  rosa_mod_unit u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (mod_start),
    .dividend  (rnd_r),
    .divisor   (cnt_r),
    .done      (mod_done),
    .remainder (pick)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      rd_vld_r    <= 1'b0;
    end else begin
      rd_vld_r <= rd_en;
      // A new result may replace the word that leaves the output in this cycle.
      if (state_r == S_DONE && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r <= S_CNT;
          end
        end
        S_CNT: begin
          if (scan_end) begin
            if (mod_start) begin
              state_r <= S_MOD;
            end else begin
              state_r <= S_DONE;
            end
          end
        end
        S_MOD: begin
          if (mod_done) begin
            state_r <= S_PICK;
          end
        end
        S_PICK: begin
          if (scan_end) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          // Hold the new result until the previous word has left the output.
          if (!out_valid_r || out_ready) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath registers carry no reset.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_idx_r   <= rd_idx_r + 1'b1;
      data_idx_r <= rd_idx_r[IDX_W-1:0];
    end
    if (state_r == S_IDLE && in_valid) begin
      action_r <= in_action;
      owner_r  <= OWNER_BITS'(in_owner_id);
      rnd_r    <= in_random_value;
      n_r      <= n_nxt;
      rd_idx_r <= '0;
      cnt_r    <= '0;
      seen_r   <= '0;
      hit_r    <= 1'b0;
    end
    if (state_r == S_MOD) begin
      rd_idx_r <= '0;
    end
    if (rd_vld_r && state_r == S_CNT) begin
      if ((action_r == ACT_ACQUIRE) ? is_cand : is_mine) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
    if (rd_vld_r && state_r == S_PICK && is_cand) begin
      seen_r <= seen_r + 1'b1;
    end
    if (is_pick) begin
      hit_r     <= 1'b1;
      hit_idx_r <= data_idx_r;
    end
    if (state_r == S_DONE && (!out_valid_r || out_ready)) begin
      if (action_r == ACT_RELEASE) begin
        out_found_r          <= 1'b0;
        out_slot_index_r     <= '0;
        out_released_count_r <= REL_W'(cnt_r);
      end else begin
        out_found_r          <= hit_r;
        out_slot_index_r     <= hit_r ? SLOT_W'(hit_idx_r) : '0;
        out_released_count_r <= '0;
      end
    end
  end

  assign in_ready           = (state_r == S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_found          = out_found_r;
  assign out_slot_index     = out_slot_index_r;
  assign out_released_count = out_released_count_r;

endmodule
`default_nettype wire

@@ hdl/rosa_chk.sv @@
`default_nettype none
module rosa_chk (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             in_valid,
  input wire logic                             in_ready,
  input wire logic                             out_valid,
  input wire logic                             out_ready,
  input wire logic                             out_found,
  input wire logic [rosa_pkg::SLOT_W-1:0]      out_slot_index,
  input wire logic [rosa_pkg::REL_W-1:0]       out_released_count
);
  import rosa_pkg::*;

  // A stalled result word holds still.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_found) &&
    $stable(out_slot_index) && $stable(out_released_count))
    else $error("result word changed while stalled");

  // A grant never reports cleared slots.
  a_grant_no_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> out_released_count == '0)
    else $error("grant with nonzero released count");

  // Without a grant the slot index is zero.
  a_idx_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_slot_index == '0)
    else $error("slot index set without a grant");

  // One word at a time: the input closes right after an acceptance.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after an acceptance");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind random_owner_slot_allocator_unit rosa_chk u_rosa_chk (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_ready           (in_ready),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_found          (out_found),
  .out_slot_index     (out_slot_index),
  .out_released_count (out_released_count)
);
`default_nettype wire
